// File: rtl/gap_pkg.sv
// ----------------------------------------------------------------------------
// gap_pkg: shared types and constants for global average pooling
// Field widths, size limits, register indexes and the transaction types
// passed between the front end, the plane queue and the divider.
// ----------------------------------------------------------------------------
package gap_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int SUM_BITS       = 28;
   localparam int SIDE_BITS      = 7;
   localparam int SIZE_BITS      = 13;
   localparam int CHAN_CFG_BITS  = 13;
   localparam int BATCH_CFG_BITS = 9;
   localparam int CHAN_BITS      = 12;
   localparam int IMG_BITS       = 8;
   localparam int THR_BITS       = 15;

   localparam int MAX_PLANE_SIDE = 64;
   localparam int MAX_CHANNELS   = 4096;
   localparam int MAX_IMAGES     = 256;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 15;

   localparam int QUEUE_DEPTH    = 2;

   localparam int DIV_STEPS      = SUM_BITS;
   localparam int STEP_BITS      = $clog2(DIV_STEPS);

   localparam int RSP_DATA_BITS  = 40;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PLANE_WIDTH     = 3'd0,
      CSR_PLANE_HEIGHT    = 3'd1,
      CSR_CHANNEL_COUNT   = 3'd2,
      CSR_BATCH_COUNT     = 3'd3,
      CSR_PRUNE_ENABLE    = 3'd4,
      CSR_PRUNE_THRESHOLD = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE   = 2'd0,
      DIV_DIVIDE = 2'd1,
      DIV_DONE   = 2'd2
   } div_state_type;

   typedef struct packed {
      logic [SIDE_BITS-1:0]      plane_width;
      logic [SIDE_BITS-1:0]      plane_height;
      logic [CHAN_CFG_BITS-1:0]  channel_count;
      logic [BATCH_CFG_BITS-1:0] batch_count;
      logic                      prune_enable;
      logic [THR_BITS-1:0]       prune_threshold;
   } cfg_type;

   // One finished plane, waiting for its division.
   typedef struct packed {
      logic signed [SUM_BITS-1:0] plane_sum;
      logic [SIZE_BITS-1:0]       plane_size;
      logic [CHAN_BITS-1:0]       channel_index;
      logic [IMG_BITS-1:0]        image_index;
      logic                       last;
      logic                       prune_enable;
      logic [THR_BITS-1:0]        prune_threshold;
   } plane_job_type;

endpackage

// File: rtl/gap_front.sv
// ----------------------------------------------------------------------------
// gap_front: sample accumulator and plane sequencer
// Add up each plane, track sample, channel and image position, and hand one
// plane job to the queue on the plane's last sample.
// ----------------------------------------------------------------------------
module gap_front (
   input  logic                                clock,
   input  logic                                reset,
   input  gap_pkg::cfg_type                    cfg,
   input  logic                                sample_valid,
   output logic                                sample_ready,
   input  logic signed [gap_pkg::SAMPLE_BITS-1:0] sample,
   output logic                                job_valid,
   input  logic                                job_ready,
   output gap_pkg::plane_job_type              job
);

   logic signed [gap_pkg::SUM_BITS-1:0]  sum_ff, sum_in;
   logic [gap_pkg::SIZE_BITS-1:0]        sample_cnt_ff, sample_cnt_in;
   logic [gap_pkg::CHAN_BITS-1:0]        chan_cnt_ff, chan_cnt_in;
   logic [gap_pkg::IMG_BITS-1:0]         img_cnt_ff, img_cnt_in;

   logic [gap_pkg::SIDE_BITS-1:0]        width_c, height_c;
   logic [gap_pkg::SIZE_BITS-1:0]        plane_size;
   logic [gap_pkg::CHAN_CFG_BITS-1:0]    chans_c;
   logic [gap_pkg::BATCH_CFG_BITS-1:0]   imgs_c;
   logic signed [gap_pkg::SUM_BITS-1:0]  sum_next;
   logic                                 plane_end, last_chan, last_img, accept;

   // Clamp the sizes into their legal ranges (zero acts as one).
   always_comb begin
      if (cfg.plane_width == '0) begin
         width_c = gap_pkg::SIDE_BITS'(1);
      end else if (cfg.plane_width > gap_pkg::SIDE_BITS'(gap_pkg::MAX_PLANE_SIDE)) begin
         width_c = gap_pkg::SIDE_BITS'(gap_pkg::MAX_PLANE_SIDE);
      end else begin
         width_c = cfg.plane_width;
      end
      if (cfg.plane_height == '0) begin
         height_c = gap_pkg::SIDE_BITS'(1);
      end else if (cfg.plane_height > gap_pkg::SIDE_BITS'(gap_pkg::MAX_PLANE_SIDE)) begin
         height_c = gap_pkg::SIDE_BITS'(gap_pkg::MAX_PLANE_SIDE);
      end else begin
         height_c = cfg.plane_height;
      end
      if (cfg.channel_count == '0) begin
         chans_c = gap_pkg::CHAN_CFG_BITS'(1);
      end else if (cfg.channel_count > gap_pkg::CHAN_CFG_BITS'(gap_pkg::MAX_CHANNELS)) begin
         chans_c = gap_pkg::CHAN_CFG_BITS'(gap_pkg::MAX_CHANNELS);
      end else begin
         chans_c = cfg.channel_count;
      end
      if (cfg.batch_count == '0) begin
         imgs_c = gap_pkg::BATCH_CFG_BITS'(1);
      end else if (cfg.batch_count > gap_pkg::BATCH_CFG_BITS'(gap_pkg::MAX_IMAGES)) begin
         imgs_c = gap_pkg::BATCH_CFG_BITS'(gap_pkg::MAX_IMAGES);
      end else begin
         imgs_c = cfg.batch_count;
      end
   end

   assign plane_size = gap_pkg::SIZE_BITS'({6'd0, width_c} * {6'd0, height_c});

   assign plane_end = ({1'b0, sample_cnt_ff} + 14'd1) >= {1'b0, plane_size};
   assign last_chan = ({1'b0, chan_cnt_ff} + 13'd1) >= chans_c;
   assign last_img  = ({1'b0, img_cnt_ff} + 9'd1) >= imgs_c;

   assign sum_next  = sum_ff + gap_pkg::SUM_BITS'(sample);

   // Stall only on a plane's last sample when the queue is full.
   assign sample_ready = job_ready || !plane_end;
   assign accept       = sample_valid && sample_ready;
   assign job_valid    = sample_valid && plane_end;

   always_comb begin
      job.plane_sum       = sum_next;
      job.plane_size      = plane_size;
      job.channel_index   = chan_cnt_ff;
      job.image_index     = img_cnt_ff;
      job.last            = last_chan && last_img;
      job.prune_enable    = cfg.prune_enable;
      job.prune_threshold = cfg.prune_threshold;
   end

   always_comb begin
      sum_in        = sum_ff;
      sample_cnt_in = sample_cnt_ff;
      chan_cnt_in   = chan_cnt_ff;
      img_cnt_in    = img_cnt_ff;
      if (accept) begin
         if (!plane_end) begin
            sum_in        = sum_next;
            sample_cnt_in = sample_cnt_ff + 1'b1;
         end else begin
            sum_in        = '0;
            sample_cnt_in = '0;
            if (last_chan) begin
               chan_cnt_in = '0;
               img_cnt_in  = last_img ? '0 : img_cnt_ff + 1'b1;
            end else begin
               chan_cnt_in = chan_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         sample_cnt_ff <= '0;
         chan_cnt_ff   <= '0;
         img_cnt_ff    <= '0;
      end else begin
         sum_ff        <= sum_in;
         sample_cnt_ff <= sample_cnt_in;
         chan_cnt_ff   <= chan_cnt_in;
         img_cnt_ff    <= img_cnt_in;
      end
   end

endmodule

// File: rtl/gap_queue.sv
// ----------------------------------------------------------------------------
// gap_queue: short plane job queue
// Decouple the accumulator from the divider so each side stalls on its own.
// ----------------------------------------------------------------------------
module gap_queue #(
   parameter int DEPTH = gap_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  gap_pkg::plane_job_type in_job,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gap_pkg::plane_job_type out_job
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   gap_pkg::plane_job_type entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = count_ff != CNT_BITS'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// File: rtl/gap_divider.sv
// ----------------------------------------------------------------------------
// gap_divider: serial plane-average divider with output register
// Divide the plane sum by the plane size one quotient bit per cycle,
// truncate toward zero, apply pruning and hold the result for the consumer.
// ----------------------------------------------------------------------------
module gap_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 job_valid,
   output logic                                 job_ready,
   input  gap_pkg::plane_job_type               job,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gap_pkg::SAMPLE_BITS-1:0] rsp_average,
   output logic [gap_pkg::CHAN_BITS-1:0]        rsp_channel_index,
   output logic [gap_pkg::IMG_BITS-1:0]         rsp_image_index,
   output logic                                 rsp_last
);

   gap_pkg::div_state_type state_ff, state_in;

   logic [gap_pkg::SUM_BITS-1:0]   dq_ff, dq_in;
   logic [gap_pkg::SIZE_BITS-1:0]  rem_ff, rem_in;
   logic [gap_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                           neg_ff;
   logic [gap_pkg::SIZE_BITS-1:0]  divisor_ff;
   logic [gap_pkg::CHAN_BITS-1:0]  chan_ff;
   logic [gap_pkg::IMG_BITS-1:0]   img_ff;
   logic                           last_ff;
   logic                           prune_en_ff;
   logic [gap_pkg::THR_BITS-1:0]   prune_thr_ff;

   logic                           out_valid_ff, out_valid_in;
   logic signed [gap_pkg::SAMPLE_BITS-1:0] out_avg_ff;
   logic [gap_pkg::CHAN_BITS-1:0]  out_chan_ff;
   logic [gap_pkg::IMG_BITS-1:0]   out_img_ff;
   logic                           out_last_ff;

   logic                           load, step_en, out_load;
   logic [gap_pkg::SIZE_BITS:0]    trial, trial_diff;
   logic                           fits;
   logic                           pruned;
   logic [gap_pkg::SAMPLE_BITS-1:0] quot_lo, avg_value;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gap_pkg::DIV_IDLE: begin
            if (job_valid) begin
               state_in = gap_pkg::DIV_DIVIDE;
            end
         end
         gap_pkg::DIV_DIVIDE: begin
            if (step_ff == gap_pkg::STEP_BITS'(gap_pkg::DIV_STEPS - 1)) begin
               state_in = gap_pkg::DIV_DONE;
            end
         end
         gap_pkg::DIV_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               state_in = gap_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = gap_pkg::DIV_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      job_ready = 1'b0;
      step_en   = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         gap_pkg::DIV_IDLE: begin
            job_ready = 1'b1;
         end
         gap_pkg::DIV_DIVIDE: begin
            step_en = 1'b1;
         end
         gap_pkg::DIV_DONE: begin
            out_load = !out_valid_ff || rsp_ready;
         end
         default: begin
            job_ready = 1'b0;
         end
      endcase
   end

   assign load = job_valid && job_ready;

   // One restoring step: shift the next dividend bit into the remainder.
   assign trial      = {rem_ff, dq_ff[gap_pkg::SUM_BITS-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign fits       = trial >= {1'b0, divisor_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (load) begin
         dq_in   = job.plane_sum[gap_pkg::SUM_BITS-1] ?
                   gap_pkg::SUM_BITS'(-job.plane_sum) : job.plane_sum;
         rem_in  = '0;
         step_in = '0;
      end else if (step_en) begin
         dq_in   = {dq_ff[gap_pkg::SUM_BITS-2:0], fits};
         rem_in  = fits ? trial_diff[gap_pkg::SIZE_BITS-1:0] : trial[gap_pkg::SIZE_BITS-1:0];
         step_in = step_ff + 1'b1;
      end
   end

   // Prune on the full quotient magnitude, then restore the sign.
   assign pruned    = prune_en_ff && (dq_ff <= gap_pkg::SUM_BITS'(prune_thr_ff));
   assign quot_lo   = dq_ff[gap_pkg::SAMPLE_BITS-1:0];
   assign avg_value = pruned ? '0 : (neg_ff ? -quot_lo : quot_lo);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gap_pkg::DIV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (load) begin
         neg_ff       <= job.plane_sum[gap_pkg::SUM_BITS-1];
         divisor_ff   <= job.plane_size;
         chan_ff      <= job.channel_index;
         img_ff       <= job.image_index;
         last_ff      <= job.last;
         prune_en_ff  <= job.prune_enable;
         prune_thr_ff <= job.prune_threshold;
      end
      if (out_load) begin
         out_avg_ff  <= avg_value;
         out_chan_ff <= chan_ff;
         out_img_ff  <= img_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_average       = out_avg_ff;
   assign rsp_channel_index = out_chan_ff;
   assign rsp_image_index   = out_img_ff;
   assign rsp_last          = out_last_ff;

endmodule

// File: rtl/global_average_pool_core.sv
// ----------------------------------------------------------------------------
// global_average_pool_core: global average pooling over Q8.8 sample streams
// Throughput: one sample per cycle, but a plane's last sample stalls while the
// queue is full; the serial divider takes one plane at a time (28 quotient
// steps plus load and hand-off), and its result is registered.
// Reset: synchronous; clears counters, sum, queue and divider, and loads the
// register defaults (7x7 plane, one channel, one image, pruning off).
// ----------------------------------------------------------------------------
module global_average_pool_core #(
   parameter int QUEUE_DEPTH = gap_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // Sample stream in.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gap_pkg::SAMPLE_BITS-1:0]     req_tdata,   // [15:0] sample
   // Average stream out.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] average, [27:16] channel_index, [35:28] image_index, [39:36] zero
   output logic [gap_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                rsp_tlast,   // last average of batch
   // Register write port.
   input  logic                                csr_we,
   input  logic [gap_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gap_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   gap_pkg::cfg_type       cfg_ff, cfg_in;
   gap_pkg::plane_job_type front_job, queue_job;
   logic                   front_job_valid, front_job_ready;
   logic                   queue_job_valid, queue_job_ready;

   logic signed [gap_pkg::SAMPLE_BITS-1:0] rsp_average;
   logic [gap_pkg::CHAN_BITS-1:0]          rsp_channel_index;
   logic [gap_pkg::IMG_BITS-1:0]           rsp_image_index;

   // Register writes: truncate the data to each register's width; drop
   // writes to indexes outside the register list.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (gap_pkg::csr_index_type'(csr_index))
            gap_pkg::CSR_PLANE_WIDTH: begin
               cfg_in.plane_width = csr_wdata[gap_pkg::SIDE_BITS-1:0];
            end
            gap_pkg::CSR_PLANE_HEIGHT: begin
               cfg_in.plane_height = csr_wdata[gap_pkg::SIDE_BITS-1:0];
            end
            gap_pkg::CSR_CHANNEL_COUNT: begin
               cfg_in.channel_count = csr_wdata[gap_pkg::CHAN_CFG_BITS-1:0];
            end
            gap_pkg::CSR_BATCH_COUNT: begin
               cfg_in.batch_count = csr_wdata[gap_pkg::BATCH_CFG_BITS-1:0];
            end
            gap_pkg::CSR_PRUNE_ENABLE: begin
               cfg_in.prune_enable = csr_wdata[0];
            end
            gap_pkg::CSR_PRUNE_THRESHOLD: begin
               cfg_in.prune_threshold = csr_wdata[gap_pkg::THR_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plane_width     <= gap_pkg::SIDE_BITS'(7);
         cfg_ff.plane_height    <= gap_pkg::SIDE_BITS'(7);
         cfg_ff.channel_count   <= gap_pkg::CHAN_CFG_BITS'(1);
         cfg_ff.batch_count     <= gap_pkg::BATCH_CFG_BITS'(1);
         cfg_ff.prune_enable    <= 1'b0;
         cfg_ff.prune_threshold <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accumulate samples, emit one job per finished plane.
   gap_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .sample_valid (req_tvalid),
      .sample_ready (req_tready),
      .sample       (req_tdata),
      .job_valid    (front_job_valid),
      .job_ready    (front_job_ready),
      .job          (front_job)
   );

   // Hold finished planes while the divider is busy.
   gap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_job_valid),
      .in_ready  (front_job_ready),
      .in_job    (front_job),
      .out_valid (queue_job_valid),
      .out_ready (queue_job_ready),
      .out_job   (queue_job)
   );

   // Back end: divide, prune, register the result transaction.
   gap_divider u_divider (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (queue_job_valid),
      .job_ready         (queue_job_ready),
      .job               (queue_job),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_average       (rsp_average),
      .rsp_channel_index (rsp_channel_index),
      .rsp_image_index   (rsp_image_index),
      .rsp_last          (rsp_tlast)
   );

   // Pack the result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {4'd0, rsp_image_index, rsp_channel_index, rsp_average};

endmodule
